// ===== sv/rrsc_pkg.sv =====
// Package for the resource request safety check: widths, operation and verdict codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrsc_pkg;
  localparam int MaxProcesses = 16;
  localparam int MaxResources = 8;
  localparam int CountWidth = 16;

  typedef enum logic [1:0] {
    OP_SET_AVAIL = 2'd0,
    OP_SET_CLAIM = 2'd1,
    OP_REQUEST   = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    V_ACCEPT  = 2'd0,
    V_CLAIM   = 2'd1,
    V_INSUFF  = 2'd2,
    V_UNSAFE  = 2'd3
  } verdict_t;

  localparam logic [1:0] RegProcCount = 2'd0;
  localparam logic [1:0] RegResCount  = 2'd1;
endpackage
`default_nettype wire

// ===== sv/rrsc_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
`default_nettype none
interface rrsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] process_index;
  logic [2:0] resource_index;
  logic [15:0] amount;
  logic       last;
  modport source(output valid, operation, process_index, resource_index, amount, last,
                 input ready);
  modport sink(input valid, operation, process_index, resource_index, amount, last,
               output ready);
endinterface

interface rrsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [3:0] decided_process;
  modport source(output valid, verdict, decided_process, input ready);
  modport sink(input valid, verdict, decided_process, output ready);
endinterface
`default_nettype wire

// ===== sv/resource_request_safety_check_top.sv =====
// Top level of the resource request safety check (banker's algorithm).
// Depends on rrsc_pkg and the channel interfaces in rrsc_if.sv.
`timescale 1ns / 1ps
`default_nettype none
// Load and non-final request words are taken only while idle. A final request word starts a
// decision that walks the (process, resource) pairs one at a time, with a read state before
// each compare or add: first the claim and availability checks over each resource, then a
// state that seeds the work vector, then safety passes in which an unfinished process is
// compared resource by resource, a process that fits adds its holdings resource by resource,
// and every process takes a pass state to move on; at most P+1 passes run. Committing walks
// all MAX_RESOURCES resources and a last state hands out the result. A result that is not yet
// taken holds the next decision in its last state; no words are taken meanwhile. The claim
// and allocation tables are memories with one read port, which is why each compare or add
// waits for a read state. After reset a clearing pass over all MAX_PROCESSES*MAX_RESOURCES
// entries zeroes those tables before the first word is taken.
module resource_request_safety_check_top #(
  parameter int MAX_PROCESSES = rrsc_pkg::MaxProcesses,
  parameter int MAX_RESOURCES = rrsc_pkg::MaxResources,
  parameter int COUNT_WIDTH = rrsc_pkg::CountWidth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rrsc_in_if.sink          in_ch,
  rrsc_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int PW = $clog2(MAX_PROCESSES);
  localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
  localparam int AW = $clog2(DEPTH) + 1;
  localparam int CW = COUNT_WIDTH;
  localparam int WW = COUNT_WIDTH + 1;
  localparam int PCW = PW + 1;
  localparam int RCW = $clog2(MAX_RESOURCES + 1);
  localparam logic [WW-1:0] WorkMax = {WW{1'b1}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHK_RD, S_CHK, S_SEED, S_SCAN_RD, S_SCAN, S_ADD_RD, S_ADD,
    S_PASS, S_COMMIT_RD, S_COMMIT, S_OUT
  } state_t;

  state_t state;
  logic [PCW-1:0] process_count;
  logic [RCW-1:0] resource_count;
  logic [CW-1:0] available [MAX_RESOURCES];
  logic [CW-1:0] pending [MAX_RESOURCES];
  logic [WW-1:0] work [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] finished;
  logic [CW-1:0] claim_mem [DEPTH];
  logic [CW-1:0] alloc_mem [DEPTH];
  logic [CW-1:0] claim_rd, alloc_rd;
  logic [AW-1:0] clr_cnt;
  logic [PW-1:0] x_proc, p_cur;
  logic [RW-1:0] r_cur;
  logic chk_fail_claim, chk_fail_avail, progress;
  logic [1:0] verdict;
  logic [3:0] dproc;
  logic out_valid;
  logic [1:0] out_verdict;
  logic [3:0] out_dproc;

  logic [AW-2:0] rd_addr;
  logic [CW:0] extra, held, need;
  logic [WW:0] wsum;
  logic is_x;
  logic r_last, p_last;
  logic [MAX_PROCESSES:0] pmask;
  logic [PCW-1:0] pc_wr;
  logic [RCW-1:0] rc_wr;
  logic cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == rrsc_pkg::RegProcCount[0]) prdata[PCW-1:0] = process_count;
    else prdata[RCW-1:0] = resource_count;
  end
  always_comb begin
    pc_wr = (pwdata[4:0] == 5'd0) ? PCW'(1) :
            ({27'd0, pwdata[4:0]} > 32'(MAX_PROCESSES)) ? PCW'(MAX_PROCESSES) :
            PCW'(pwdata[4:0]);
    rc_wr = (pwdata[3:0] == 4'd0) ? RCW'(1) :
            ({28'd0, pwdata[3:0]} > 32'(MAX_RESOURCES)) ? RCW'(MAX_RESOURCES) :
            RCW'(pwdata[3:0]);
  end

  assign rd_addr = (AW-1)'(p_cur) * (AW-1)'(MAX_RESOURCES) + (AW-1)'(r_cur);
  assign is_x = (p_cur == x_proc);
  assign extra = is_x ? {1'b0, pending[r_cur]} : '0;
  assign held = {1'b0, alloc_rd} + extra;
  assign need = (held >= {1'b0, claim_rd}) ? '0 : {1'b0, claim_rd} - held;
  assign wsum = {1'b0, work[r_cur]} + {2'b0, held[CW-1:0]} + (held[CW] ? (WW+1)'(1) << CW : '0);
  assign r_last = ({1'b0, r_cur} + 1'b1) >= (RW+1)'(resource_count);
  assign p_last = ({1'b0, p_cur} + 1'b1) >= (PW+1)'(process_count);
  assign pmask = ((MAX_PROCESSES+1)'(1) << process_count) - 1'b1;

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.verdict = out_verdict;
  assign out_ch.decided_process = out_dproc;

  always_ff @(posedge clk) begin
    claim_rd <= claim_mem[rd_addr];
    alloc_rd <= alloc_mem[rd_addr];
    if (state == S_CLEAR) begin
      claim_mem[clr_cnt[AW-2:0]] <= '0;
      alloc_mem[clr_cnt[AW-2:0]] <= '0;
    end else if (state == S_IDLE && in_ch.valid && in_ch.ready &&
                 in_ch.operation == rrsc_pkg::OP_SET_CLAIM &&
                 32'(in_ch.process_index) < 32'(MAX_PROCESSES) &&
                 32'(in_ch.resource_index) < 32'(MAX_RESOURCES)) begin
      claim_mem[(AW-1)'(in_ch.process_index) * (AW-1)'(MAX_RESOURCES)
                + (AW-1)'(in_ch.resource_index)] <= in_ch.amount[CW-1:0];
      alloc_mem[(AW-1)'(in_ch.process_index) * (AW-1)'(MAX_RESOURCES)
                + (AW-1)'(in_ch.resource_index)] <= '0;
    end else if (state == S_COMMIT && {1'b0, r_cur} < (RW+1)'(resource_count)) begin
      alloc_mem[rd_addr] <= alloc_rd + pending[r_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      process_count <= PCW'(MAX_PROCESSES);
      resource_count <= RCW'(MAX_RESOURCES);
      for (int i = 0; i < MAX_RESOURCES; i++) begin
        available[i] <= '0;
        pending[i] <= '0;
      end
      finished <= '0;
      out_valid <= 1'b0;
      p_cur <= '0;
      r_cur <= '0;
      x_proc <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == rrsc_pkg::RegProcCount[0]) process_count <= pc_wr;
        else resource_count <= rc_wr;
      end
      if (out_valid && out_ch.ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            unique case (in_ch.operation)
              rrsc_pkg::OP_SET_AVAIL: begin
                if (32'(in_ch.resource_index) < 32'(MAX_RESOURCES))
                  available[RW'(in_ch.resource_index)] <= in_ch.amount[CW-1:0];
              end
              rrsc_pkg::OP_REQUEST: begin
                if (32'(in_ch.resource_index) < 32'(MAX_RESOURCES))
                  pending[RW'(in_ch.resource_index)] <= in_ch.amount[CW-1:0];
                if (in_ch.last) begin
                  dproc <= in_ch.process_index;
                  x_proc <= PW'(in_ch.process_index);
                  p_cur <= PW'(in_ch.process_index);
                  r_cur <= '0;
                  chk_fail_claim <= {1'b0, in_ch.process_index} >= 5'(process_count);
                  chk_fail_avail <= 1'b0;
                  state <= S_CHK_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_CHK_RD: state <= S_CHK;
        S_CHK: begin
          if ({1'b0, alloc_rd} + {1'b0, pending[r_cur]} > {1'b0, claim_rd})
            chk_fail_claim <= 1'b1;
          if (pending[r_cur] > available[r_cur]) chk_fail_avail <= 1'b1;
          if (r_last) begin
            r_cur <= '0;
            state <= S_SEED;
          end else begin
            r_cur <= r_cur + 1'b1;
            state <= S_CHK_RD;
          end
        end
        S_SEED: begin
          if (chk_fail_claim) begin
            verdict <= rrsc_pkg::V_CLAIM;
            state <= S_OUT;
          end else if (chk_fail_avail) begin
            verdict <= rrsc_pkg::V_INSUFF;
            state <= S_OUT;
          end else begin
            for (int i = 0; i < MAX_RESOURCES; i++)
              work[i] <= {1'b0, available[i] - pending[i]};
            finished <= '0;
            progress <= 1'b0;
            p_cur <= '0;
            r_cur <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (finished[p_cur]) state <= S_PASS;
          else state <= S_SCAN;
        end
        S_SCAN: begin
          if (need[CW-1:0] > work[r_cur][CW-1:0] && work[r_cur][CW] == 1'b0 || need[CW]) begin
            r_cur <= '0;
            state <= S_PASS;
          end else if (r_last) begin
            r_cur <= '0;
            state <= S_ADD_RD;
          end else begin
            r_cur <= r_cur + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_ADD_RD: state <= S_ADD;
        S_ADD: begin
          work[r_cur] <= (wsum > {1'b0, WorkMax}) ? WorkMax : wsum[WW-1:0];
          if (r_last) begin
            finished[p_cur] <= 1'b1;
            progress <= 1'b1;
            r_cur <= '0;
            state <= S_PASS;
          end else begin
            r_cur <= r_cur + 1'b1;
            state <= S_ADD_RD;
          end
        end
        S_PASS: begin
          r_cur <= '0;
          if (!p_last) begin
            p_cur <= p_cur + 1'b1;
            state <= S_SCAN_RD;
          end else if (progress) begin
            progress <= 1'b0;
            p_cur <= '0;
            state <= S_SCAN_RD;
          end else if (({1'b0, finished} & pmask) == pmask) begin
            p_cur <= x_proc;
            state <= S_COMMIT_RD;
          end else begin
            verdict <= rrsc_pkg::V_UNSAFE;
            state <= S_OUT;
          end
        end
        S_COMMIT_RD: state <= S_COMMIT;
        S_COMMIT: begin
          if ({1'b0, r_cur} < (RW+1)'(resource_count))
            available[r_cur] <= available[r_cur] - pending[r_cur];
          if (32'(r_cur) == MAX_RESOURCES - 1) begin
            verdict <= rrsc_pkg::V_ACCEPT;
            state <= S_OUT;
          end else begin
            r_cur <= r_cur + 1'b1;
            state <= S_COMMIT_RD;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_verdict <= verdict;
            out_dproc <= dproc;
            for (int i = 0; i < MAX_RESOURCES; i++) pending[i] <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT) else $error("result without decision");
  a_counts_ok: assert property (@(posedge clk) disable iff (rst)
    process_count != '0 && resource_count != '0) else $error("zero count");
endmodule
`default_nettype wire
